// File: hw/rtl/tms_pkg.sv
package tms_pkg;

    // iteration counts of the shared units
    localparam int SQRT_STEPS   = 25;
    localparam int CORDIC_STEPS = 18;
    localparam int CNT_W        = 5;
    localparam int ANG_FULL     = 23040;

    // configuration register indexes
    localparam logic [2:0] CFG_PIXEL_RATIO = 3'd0;
    localparam logic [2:0] CFG_FRAME_RATE  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X    = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
    localparam logic [2:0] CFG_QUAD_ONE    = 3'd4;
    localparam logic [2:0] CFG_QUAD_TWO    = 3'd5;
    localparam logic [2:0] CFG_QUAD_THREE  = 3'd6;
    localparam logic [2:0] CFG_QUAD_FOUR   = 3'd7;

    localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] ACC_MIN = -50'sh0_8000_0000_0000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             sq_x;
        logic             sq_y;
        logic             sq_step;
        logic             mul_d;
        logic             dst;
        logic             sel_b;
        logic             spd;
        logic             acc;
        logic             ang_init;
        logic             ang_step;
        logic [CNT_W-1:0] step;
        logic             ang_fin;
        logic             out_load;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_dist;
        logic second;
        logic out_free;
    } t_sts;

    // arctangent table in 1/65536 degree
    function automatic logic signed [24:0] atan_entry(input logic [CNT_W-1:0] i);
        logic signed [24:0] v;
        v = '0;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

    // arithmetic shift right that truncates toward zero
    function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                  input logic [CNT_W-1:0] s);
        logic [33:0] mag;
        logic [33:0] sh;
        mag = v[33] ? 34'(-v) : 34'(v);
        sh  = mag >> s;
        return v[33] ? -$signed(sh) : $signed(sh);
    endfunction

    // angle strictly between two boundaries, with wrap-around
    function automatic logic in_sector(input logic [14:0] sup, input logic [14:0] inf,
                                       input logic [14:0] ang);
        if (inf < sup) begin
            return (ang > inf) && (ang < sup);
        end
        return ((ang > inf) && (ang < 15'(ANG_FULL))) || (ang < sup);
    endfunction

endpackage

// File: hw/rtl/tms_ctrl.sv
module tms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  tms_pkg::t_sts  i_sts,
    output tms_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEC, ST_SQX, ST_SQY, ST_SQR, ST_MULD, ST_DST,
        ST_SPD, ST_ACC, ST_AINIT, ST_ASTEP, ST_AFIN, ST_OUT
    } t_state;

    t_state                      r_state;
    logic [tms_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_sel_b;
    logic                        w_accept;

    assign o_s_ready = (r_state == ST_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel_b <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) r_state <= ST_DEC;
                end
                ST_DEC: begin
                    r_sel_b <= 1'b0;
                    r_state <= i_sts.need_dist ? ST_SQX : ST_AINIT;
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_cnt   <= '0;
                    r_state <= ST_SQR;
                end
                ST_SQR: begin
                    if (r_cnt == tms_pkg::CNT_W'(tms_pkg::SQRT_STEPS - 1)) begin
                        r_state <= ST_MULD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MULD: r_state <= ST_DST;
                ST_DST: begin
                    if (!r_sel_b && !i_sts.second) begin
                        r_sel_b <= 1'b1;
                        r_state <= ST_SQX;
                    end else begin
                        r_state <= ST_SPD;
                    end
                end
                ST_SPD:   r_state <= ST_ACC;
                ST_ACC:   r_state <= ST_AINIT;
                ST_AINIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_ASTEP;
                end
                ST_ASTEP: begin
                    if (r_cnt == tms_pkg::CNT_W'(tms_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= ST_AFIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_AFIN: r_state <= ST_OUT;
                ST_OUT: begin
                    if (i_sts.out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.sel_b    = r_sel_b;
        o_cmd.step     = r_cnt;
        o_cmd.sq_x     = (r_state == ST_SQX);
        o_cmd.sq_y     = (r_state == ST_SQY);
        o_cmd.sq_step  = (r_state == ST_SQR);
        o_cmd.mul_d    = (r_state == ST_MULD);
        o_cmd.dst      = (r_state == ST_DST);
        o_cmd.spd      = (r_state == ST_SPD);
        o_cmd.acc      = (r_state == ST_ACC);
        o_cmd.ang_init = (r_state == ST_AINIT);
        o_cmd.ang_step = (r_state == ST_ASTEP);
        o_cmd.ang_fin  = (r_state == ST_AFIN);
        o_cmd.out_load = (r_state == ST_OUT) && i_sts.out_free;
    end

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQR) |-> (r_cnt <= tms_pkg::CNT_W'(tms_pkg::SQRT_STEPS - 1)))
        else $error("sqrt step count out of range");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a waiting item");

    a_second_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQX && r_sel_b) |-> (i_sts.need_dist && !i_sts.second))
        else $error("earlier step measured when not needed");

    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DEC))
        else $error("accepted item not decoded");

endmodule

// File: hw/rtl/tms_dp.sv
module tms_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tms_pkg::t_cmd  i_cmd,
    output tms_pkg::t_sts  o_sts,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [23:0]    i_cfg_data,
    input  logic           i_found,
    input  logic [15:0]    i_pos_x,
    input  logic [15:0]    i_pos_y,
    input  logic           i_m_ready,
    output logic           o_m_valid,
    output logic [31:0]    o_frame_number,
    output logic [31:0]    o_distance,
    output logic [39:0]    o_speed,
    output logic [47:0]    o_acceleration,
    output logic [2:0]     o_quadrant
);

    logic [23:0] r_pr;
    logic [7:0]  r_fr;
    logic [15:0] r_cx, r_cy;
    logic [14:0] r_q1, r_q2, r_q3, r_q4;

    logic [31:0] r_cur, r_prev, r_old, r_fc;
    logic        r_found;

    logic [49:0] r_v, r_root, r_bit;
    logic [48:0] r_prod;
    logic [31:0] r_dist_a, r_dist_b;
    logic [39:0] r_speed, r_sb;
    logic signed [49:0] r_accw;

    logic signed [33:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic [14:0]        r_off;
    logic               r_axis;
    logic [2:0]         r_quad;
    logic               r_mv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr <= 24'd65536;
            r_fr <= 8'd30;
            r_cx <= '0;
            r_cy <= '0;
            r_q1 <= 15'd5760;
            r_q2 <= 15'd11520;
            r_q3 <= 15'd17280;
            r_q4 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tms_pkg::CFG_PIXEL_RATIO: r_pr <= i_cfg_data;
                tms_pkg::CFG_FRAME_RATE:  r_fr <= i_cfg_data[7:0];
                tms_pkg::CFG_CENTER_X:    r_cx <= i_cfg_data[15:0];
                tms_pkg::CFG_CENTER_Y:    r_cy <= i_cfg_data[15:0];
                tms_pkg::CFG_QUAD_ONE:    r_q1 <= i_cfg_data[14:0];
                tms_pkg::CFG_QUAD_TWO:    r_q2 <= i_cfg_data[14:0];
                tms_pkg::CFG_QUAD_THREE:  r_q3 <= i_cfg_data[14:0];
                tms_pkg::CFG_QUAD_FOUR:   r_q4 <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // position history and frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_prev  <= '0;
            r_old   <= '0;
            r_fc    <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= i_found;
            if (r_fc != 32'hFFFF_FFFF) r_fc <= r_fc + 1'b1;
            if (i_found) begin
                r_old  <= r_prev;
                r_prev <= r_cur;
                r_cur  <= {i_pos_y, i_pos_x};
            end else begin
                r_cur <= r_prev;
            end
        end
    end

    assign o_sts.need_dist = r_found && (r_fc != 32'd1);
    assign o_sts.second    = (r_fc == 32'd2);
    assign o_sts.out_free  = !r_mv || i_m_ready;

    // step deltas of the selected pair
    logic [31:0]        w_pa, w_pb;
    logic signed [16:0] w_dx, w_dy, w_d;
    logic signed [33:0] w_sq;
    logic [49:0]        w_sq_sh, w_trial;
    logic [48:0]        w_rnd;

    assign w_pa    = i_cmd.sel_b ? r_old : r_prev;
    assign w_pb    = i_cmd.sel_b ? r_prev : r_cur;
    assign w_dx    = $signed({1'b0, w_pa[15:0]}) - $signed({1'b0, w_pb[15:0]});
    assign w_dy    = $signed({1'b0, w_pa[31:16]}) - $signed({1'b0, w_pb[31:16]});
    assign w_d     = i_cmd.sq_y ? w_dy : w_dx;
    assign w_sq    = w_d * w_d;
    assign w_sq_sh = {2'b00, w_sq[31:0], 16'h0000};
    assign w_trial = r_root + r_bit;
    assign w_rnd   = r_prod + 49'h8_0000;

    // square root, scaling, speed and acceleration
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_x) begin
            r_v <= w_sq_sh;
        end
        if (i_cmd.sq_y) begin
            r_v    <= r_v + w_sq_sh;
            r_root <= '0;
            r_bit  <= 50'h1 << 48;
        end
        if (i_cmd.sq_step) begin
            if (r_v >= w_trial) begin
                r_v    <= r_v - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mul_d) begin
            r_prod <= r_root[24:0] * r_pr;
        end
        if (i_cmd.dst) begin
            if (i_cmd.sel_b) r_dist_b <= {3'b000, w_rnd[48:20]};
            else             r_dist_a <= {3'b000, w_rnd[48:20]};
        end
        if (i_cmd.spd) begin
            r_speed <= r_dist_a * r_fr;
            r_sb    <= r_dist_b * r_fr;
        end
        if (i_cmd.acc) begin
            r_accw <= (o_sts.second ? $signed({1'b0, r_speed})
                                    : $signed({1'b0, r_speed}) - $signed({1'b0, r_sb}))
                      * $signed({1'b0, r_fr});
        end
    end

    // angle setup about the arena centre
    logic signed [16:0] w_a, w_b;
    logic [15:0]        w_p, w_q;
    logic [14:0]        w_off;
    logic               w_axis;

    assign w_a = $signed({1'b0, r_cur[15:0]}) - $signed({1'b0, r_cx});
    assign w_b = $signed({1'b0, r_cur[31:16]}) - $signed({1'b0, r_cy});

    always_comb begin
        w_p    = '0;
        w_q    = '0;
        w_off  = '0;
        w_axis = 1'b0;
        if (w_a > 0 && w_b < 0) begin
            w_p = 16'(-w_b);
            w_q = 16'(w_a);
        end else if (w_a < 0 && w_b < 0) begin
            w_p   = 16'(-w_a);
            w_q   = 16'(-w_b);
            w_off = 15'd5760;
        end else if (w_a < 0 && w_b > 0) begin
            w_p   = 16'(w_b);
            w_q   = 16'(-w_a);
            w_off = 15'd11520;
        end else if (w_a > 0 && w_b > 0) begin
            w_p   = 16'(w_a);
            w_q   = 16'(w_b);
            w_off = 15'd17280;
        end else begin
            w_axis = 1'b1;
        end
    end

    // cordic rotation and quadrant test
    logic signed [33:0] w_shy, w_shx;
    logic [24:0]        w_zc;
    logic [24:0]        w_zr;
    logic [14:0]        w_at, w_ang;

    assign w_shy = tms_pkg::shr_tz(r_y, i_cmd.step);
    assign w_shx = tms_pkg::shr_tz(r_x, i_cmd.step);
    assign w_zc  = r_z[24] ? 25'd0 : 25'(r_z);
    assign w_zr  = (w_zc + 25'd512) >> 10;
    assign w_at  = (w_zr > 25'd5760) ? 15'd5760 : w_zr[14:0];
    assign w_ang = r_axis ? 15'd0 : r_off + w_at;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ang_init) begin
            r_x    <= $signed({4'b0000, w_q, 14'h0000});
            r_y    <= $signed({4'b0000, w_p, 14'h0000});
            r_z    <= '0;
            r_off  <= w_off;
            r_axis <= w_axis;
        end
        if (i_cmd.ang_step) begin
            if (r_y > 0) begin
                r_x <= r_x + w_shy;
                r_y <= r_y - w_shx;
                r_z <= r_z + tms_pkg::atan_entry(i_cmd.step);
            end else begin
                r_x <= r_x - w_shy;
                r_y <= r_y + w_shx;
                r_z <= r_z - tms_pkg::atan_entry(i_cmd.step);
            end
        end
        if (i_cmd.ang_fin) begin
            if (tms_pkg::in_sector(r_q1, r_q4, w_ang))      r_quad <= 3'd1;
            else if (tms_pkg::in_sector(r_q2, r_q1, w_ang)) r_quad <= 3'd2;
            else if (tms_pkg::in_sector(r_q3, r_q2, w_ang)) r_quad <= 3'd3;
            else if (tms_pkg::in_sector(r_q4, r_q3, w_ang)) r_quad <= 3'd4;
            else                                            r_quad <= 3'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_mv <= 1'b1;
        end else if (i_m_ready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frame_number <= r_fc;
            o_quadrant     <= r_quad;
            if (o_sts.need_dist) begin
                o_distance <= r_dist_a;
                o_speed    <= r_speed;
                if (r_accw > tms_pkg::ACC_MAX)      o_acceleration <= 48'(tms_pkg::ACC_MAX);
                else if (r_accw < tms_pkg::ACC_MIN) o_acceleration <= 48'(tms_pkg::ACC_MIN);
                else                                o_acceleration <= r_accw[47:0];
            end else begin
                o_distance     <= '0;
                o_speed        <= '0;
                o_acceleration <= '0;
            end
        end
    end

    assign o_m_valid = r_mv;

endmodule

// File: hw/rtl/track_motion_statistics_top.sv
// channel  | dir | handshake                | payload
// s_       | in  | i_s_tvalid / o_s_tready  | tuser: found; tdata: pos_x, pos_y
// m_       | out | o_m_tvalid / i_m_tready  | tdata: frame_number, distance, speed,
//          |     |                          |        acceleration, quadrant
// cfg      | in  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// one item at a time; the square root runs 25 steps for each pair of positions and the cordic
// 18 steps. both step lengths are measured in general, one on the second frame and none for a
// miss or the first frame; ready returns in the same cycle that the result becomes valid.
// synchronous active-low reset restores the register defaults and clears history.
// a new item is taken while the previous result waits in the output register;
// a stalled output holds the finished item until the sink takes it.
module track_motion_statistics_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // pos_x, pos_y
    input  logic [0:0]   i_s_tuser,   // found
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // frame_number, distance, speed, acceleration, quadrant
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);

    tms_pkg::t_cmd w_cmd;
    tms_pkg::t_sts w_sts;
    logic [31:0]   w_frame, w_dist;
    logic [39:0]   w_speed;
    logic [47:0]   w_acc;
    logic [2:0]    w_quad;

    tms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    tms_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_found        (i_s_tuser[0]),
        .i_pos_x        (i_s_tdata[15:0]),
        .i_pos_y        (i_s_tdata[31:16]),
        .i_m_ready      (i_m_tready),
        .o_m_valid      (o_m_tvalid),
        .o_frame_number (w_frame),
        .o_distance     (w_dist),
        .o_speed        (w_speed),
        .o_acceleration (w_acc),
        .o_quadrant     (w_quad)
    );

    // result packing, first field lowest
    assign o_m_tdata = {5'b00000, w_quad, w_acc, w_speed, w_dist, w_frame};

endmodule
